@@ src/obp_pkg.sv @@
// Shared types and constants for the OTA bitmap packer.
`default_nettype none
package obp_pkg;

    localparam int ITEMS = 7;
    localparam int CNT_W = 3;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_IMAGE_WIDTH     = 2'd0;
    localparam reg_idx_t REG_IMAGE_HEIGHT    = 2'd1;
    localparam reg_idx_t REG_COLOR_DEPTH     = 2'd2;
    localparam reg_idx_t REG_TRANSFORM_FLAGS = 2'd3;

    localparam int FLAG_REVERSE = 0;
    localparam int FLAG_INVERT  = 1;

    localparam logic [7:0]  INFO_SHORT = 8'h00;
    localparam logic [7:0]  INFO_LONG  = 8'h10;
    localparam logic [15:0] SHORT_MAX  = 16'd255;

    typedef struct packed {
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  color_depth;
        logic [1:0]  transform_flags;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       last;
    } item_t;

    typedef struct packed {
        item_t [ITEMS-1:0] items;
        logic [CNT_W-1:0]  count;
    } bundle_t;

endpackage
`default_nettype wire

@@ src/ota_bitmap_packer_core.sv @@
// The first result byte of a source byte is registered and valid in the cycle after its transfer.
// One result byte per cycle while m_tready is high; a pixel byte yields at most one result
// byte, or two when it also flushes the final partial byte. The first byte of an image also
// yields the header: four bytes with the short header and six with the long one.
// Source bytes that only fill the bit accumulator produce no output.
// Reset: synchronous, active low; registers go to width 1, height 1, depth 1, no transform.
`default_nettype none
module ota_bitmap_packer_core
    import obp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] src_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tuser,   // [0] is_header
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    cfg_t    cfg;
    bundle_t bundle;
    item_t   m_item;
    logic    s_xfer;

    assign s_xfer = s_tvalid && s_tready;

    obp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    obp_packer u_packer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .take     (s_xfer),
        .src_byte (s_tdata),
        .bundle   (bundle)
    );

    obp_burst u_burst (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .bundle   (bundle),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_item   (m_item)
    );

    assign m_tdata = m_item.out_byte;
    assign m_tuser = m_item.is_header;
    assign m_tlast = m_item.last;

`ifndef SYNTH
    // The end of a stream is always a pixel byte, never part of a header.
    a_last_not_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |-> !m_tuser)
        else $error("last byte flagged as header");

    // With no result pending, the block must take input.
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

    // A source byte never causes more results than the bundle holds.
    a_bundle_size: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |-> bundle.count <= 3'd7)
        else $error("bundle count out of range");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire

@@ src/obp_cfg.sv @@
// Configuration register file of the OTA bitmap packer.
`default_nettype none
module obp_cfg
    import obp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire reg_idx_t    cfg_index,
    input  wire logic [15:0] cfg_wdata,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:     cfg_next.image_width     = cfg_wdata;
                REG_IMAGE_HEIGHT:    cfg_next.image_height    = cfg_wdata;
                REG_COLOR_DEPTH:     cfg_next.color_depth     = cfg_wdata[7:0];
                REG_TRANSFORM_FLAGS: cfg_next.transform_flags = cfg_wdata[1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width     <= 16'd1;
            cfg_reg.image_height    <= 16'd1;
            cfg_reg.color_depth     <= 8'd1;
            cfg_reg.transform_flags <= 2'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ src/obp_packer.sv @@
// Pixel packing state and per-byte result bundle of the OTA bitmap packer.
`default_nettype none
module obp_packer
    import obp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       take,
    input  wire logic [7:0] src_byte,
    output bundle_t         bundle
);

    logic [7:0]  acc_reg, acc_next;
    logic [2:0]  pend_reg, pend_next;
    logic [12:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic        hdr_sent_reg, hdr_sent_next;

    logic [15:0] w, h, w_m1, h_m1;
    logic [12:0] last_col;
    logic        end_row, end_img, big;
    logic [7:0]  val_rev, val_tr, mask, val_m;
    logic [3:0]  nbits, total;
    logic [15:0] word;
    logic        emit_data, flush;
    logic [2:0]  pend_after;
    logic [7:0]  acc_after;

    always_comb begin
        w        = (cfg.image_width == 16'd0) ? 16'd1 : cfg.image_width;
        h        = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
        w_m1     = w - 16'd1;
        h_m1     = h - 16'd1;
        // The last byte column of a row is (width - 1) / 8.
        last_col = w_m1[15:3];
        end_row  = col_reg >= last_col;
        end_img  = end_row && (row_reg >= h_m1);
        big      = (cfg.image_width > SHORT_MAX) || (cfg.image_height > SHORT_MAX);

        for (int i = 0; i < 8; i++) begin
            val_rev[i] = src_byte[7-i];
        end
        val_tr = cfg.transform_flags[FLAG_REVERSE] ? val_rev : src_byte;
        if (cfg.transform_flags[FLAG_INVERT]) begin
            val_tr = ~val_tr;
        end

        if (end_row && (w[2:0] != 3'd0)) begin
            nbits = {1'b0, w[2:0]};
        end else begin
            nbits = 4'd8;
        end
        mask  = ~(8'hFF >> nbits);
        val_m = val_tr & mask;

        total = {1'b0, pend_reg} + nbits;
        word  = {acc_reg, 8'h00} | ({8'h00, val_m} << (4'd8 - {1'b0, pend_reg}));

        // Whether or not a byte goes out, the low three bits of the sum are
        // the bits left pending.
        emit_data  = total[3];
        pend_after = total[2:0];
        acc_after  = emit_data ? word[7:0] : word[15:8];
        flush      = end_img && (pend_after != 3'd0);
    end

    always_comb begin
        logic [CNT_W-1:0] n;
        n = '0;
        bundle.items = '0;
        if (!hdr_sent_reg) begin
            if (big) begin
                bundle.items[0] = '{INFO_LONG, 1'b1, 1'b0};
                bundle.items[1] = '{cfg.image_width[15:8], 1'b1, 1'b0};
                bundle.items[2] = '{cfg.image_width[7:0], 1'b1, 1'b0};
                bundle.items[3] = '{cfg.image_height[15:8], 1'b1, 1'b0};
                bundle.items[4] = '{cfg.image_height[7:0], 1'b1, 1'b0};
                bundle.items[5] = '{cfg.color_depth, 1'b1, 1'b0};
                n = 3'd6;
            end else begin
                bundle.items[0] = '{INFO_SHORT, 1'b1, 1'b0};
                bundle.items[1] = '{cfg.image_width[7:0], 1'b1, 1'b0};
                bundle.items[2] = '{cfg.image_height[7:0], 1'b1, 1'b0};
                bundle.items[3] = '{cfg.color_depth, 1'b1, 1'b0};
                n = 3'd4;
            end
        end
        if (emit_data) begin
            bundle.items[n] = '{word[15:8], 1'b0, end_img && !flush};
            n = n + 3'd1;
        end
        if (flush) begin
            bundle.items[n] = '{acc_after, 1'b0, 1'b1};
            n = n + 3'd1;
        end
        bundle.count = n;
    end

    always_comb begin
        acc_next      = acc_reg;
        pend_next     = pend_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        hdr_sent_next = hdr_sent_reg;
        if (take) begin
            if (end_img) begin
                acc_next      = '0;
                pend_next     = '0;
                col_next      = '0;
                row_next      = '0;
                hdr_sent_next = 1'b0;
            end else begin
                acc_next      = acc_after;
                pend_next     = pend_after;
                hdr_sent_next = 1'b1;
                if (end_row) begin
                    col_next = '0;
                    row_next = row_reg + 16'd1;
                end else begin
                    col_next = col_reg + 13'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            pend_reg     <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            hdr_sent_reg <= 1'b0;
        end else begin
            acc_reg      <= acc_next;
            pend_reg     <= pend_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            hdr_sent_reg <= hdr_sent_next;
        end
    end

endmodule
`default_nettype wire

@@ src/obp_burst.sv @@
// Result register of the OTA bitmap packer: holds one bundle and sends it byte by byte.
`default_nettype none
module obp_burst
    import obp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire bundle_t bundle,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output item_t        m_item
);

    item_t [ITEMS-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              busy_reg, busy_next;
    logic              last_of, drain, load;

    always_comb begin
        last_of  = (idx_reg + 3'd1) == cnt_reg;
        drain    = busy_reg && m_tready && last_of;
        // A new bundle may enter in the cycle the last byte of the old one leaves.
        s_tready = !busy_reg || drain;
        load     = s_tvalid && s_tready && (bundle.count != '0);

        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load) begin
            buf_next  = bundle.items;
            cnt_next  = bundle.count;
            idx_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg && m_tready) begin
            if (last_of) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    assign m_tvalid = busy_reg;
    assign m_item   = buf_reg[idx_reg];

endmodule
`default_nettype wire

@@ bench/obp_stream_checker.sv @@
// Stream checker for the OTA bitmap packer: predicts the output bytes and compares them.
`default_nettype none
module obp_stream_checker
    import obp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    output int               mismatches,
    output int               backlog,
    output int               checked
);

    cfg_t        cfg;
    logic [7:0]  acc;
    logic [2:0]  acc_bits;
    logic [12:0] col;
    logic [15:0] row;
    logic        hdr_sent;

    item_t expected_stream[$];
    item_t step_out [ITEMS];
    int    step_n;

    task automatic emit(input logic [7:0] b, input logic hdr);
        step_out[step_n].out_byte  = b;
        step_out[step_n].is_header = hdr;
        step_out[step_n].last      = 1'b0;
        step_n++;
    endtask

    // Works out the output bytes released by one source byte and queues them.
    task automatic pack_src_byte(input logic [7:0] src);
        int          wid, hgt, row_bytes, nbits, total, i;
        logic [7:0]  pix;
        logic [15:0] word;
        logic        end_row, end_img;
        step_n = 0;
        wid = (cfg.image_width == 16'd0) ? 1 : int'(cfg.image_width);
        hgt = (cfg.image_height == 16'd0) ? 1 : int'(cfg.image_height);
        row_bytes = (wid + 7) / 8;
        if (!hdr_sent) begin
            if (cfg.image_width > SHORT_MAX || cfg.image_height > SHORT_MAX) begin
                emit(INFO_LONG, 1'b1);
                emit(cfg.image_width[15:8], 1'b1);
                emit(cfg.image_width[7:0], 1'b1);
                emit(cfg.image_height[15:8], 1'b1);
                emit(cfg.image_height[7:0], 1'b1);
            end else begin
                emit(INFO_SHORT, 1'b1);
                emit(cfg.image_width[7:0], 1'b1);
                emit(cfg.image_height[7:0], 1'b1);
            end
            emit(cfg.color_depth, 1'b1);
            hdr_sent = 1'b1;
        end
        pix = src;
        if (cfg.transform_flags[FLAG_REVERSE]) begin
            for (i = 0; i < 8; i++) pix[i] = src[7-i];
        end
        if (cfg.transform_flags[FLAG_INVERT]) pix = ~pix;
        // A column or row beyond the current bounds counts as the last one.
        end_row = int'(col) >= row_bytes - 1;
        end_img = end_row && (int'(row) >= hgt - 1);
        nbits = 8;
        if (end_row && (wid % 8) != 0) begin
            nbits = wid % 8;
            pix = pix & (8'hFF << (8 - nbits));
        end
        total = int'(acc_bits) + nbits;
        word = {acc, 8'h00} | ({8'h00, pix} << (8 - int'(acc_bits)));
        if (total >= 8) begin
            emit(word[15:8], 1'b0);
            acc = word[7:0];
        end else begin
            acc = word[15:8];
        end
        acc_bits = total[2:0];
        if (end_img) begin
            if (acc_bits != 3'd0) emit(acc, 1'b0);
            step_out[step_n-1].last = 1'b1;
            acc      = 8'h00;
            acc_bits = 3'd0;
            col      = 13'd0;
            row      = 16'd0;
            hdr_sent = 1'b0;
        end else if (end_row) begin
            col = 13'd0;
            row = row + 16'd1;
        end else begin
            col = col + 13'd1;
        end
        for (i = 0; i < step_n; i++) expected_stream.push_back(step_out[i]);
    endtask

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        mismatches++;
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
    endtask

    always @(posedge aclk) begin
        item_t got, want;
        if (!aresetn) begin
            cfg.image_width     = 16'd1;
            cfg.image_height    = 16'd1;
            cfg.color_depth     = 8'd1;
            cfg.transform_flags = 2'd0;
            acc        = 8'h00;
            acc_bits   = 3'd0;
            col        = 13'd0;
            row        = 16'd0;
            hdr_sent   = 1'b0;
            mismatches = 0;
            checked    = 0;
            expected_stream.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:     cfg.image_width     = cfg_wdata;
                    REG_IMAGE_HEIGHT:    cfg.image_height    = cfg_wdata;
                    REG_COLOR_DEPTH:     cfg.color_depth     = cfg_wdata[7:0];
                    REG_TRANSFORM_FLAGS: cfg.transform_flags = cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) pack_src_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                got.out_byte  = m_tdata;
                got.is_header = m_tuser;
                got.last      = m_tlast;
                if (expected_stream.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected output transfer, expected none, got %h",
                             $time, got);
                end else begin
                    want = expected_stream.pop_front();
                    checked++;
                    if (got.out_byte !== want.out_byte)
                        report_field("out_byte", want.out_byte, got.out_byte);
                    if (got.is_header !== want.is_header)
                        report_field("is_header", {7'b0, want.is_header},
                                     {7'b0, got.is_header});
                    if (got.last !== want.last)
                        report_field("last", {7'b0, want.last}, {7'b0, got.last});
                end
            end
        end
        backlog = expected_stream.size();
    end

endmodule
`default_nettype wire

@@ bench/ota_bitmap_packer_core_test.sv @@
// Testbench top for the OTA bitmap packer: clock, reset, stimulus, output stalls and verdict.
`default_nettype none
module ota_bitmap_packer_core_test;
    import obp_pkg::*;

    localparam int RANDOM_ITEMS = 380;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_wdata = 16'd0;

    int mismatches, backlog, checked;
    int bytes_sent = 0;
    int settings   = 0;
    bit tx_burst   = 1'b0;
    bit squeeze_req = 1'b0;

    always #10 aclk = ~aclk;

    ota_bitmap_packer_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    obp_stream_checker u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .mismatches(mismatches), .backlog(backlog), .checked(checked)
    );

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] d, input logic [15:0] f);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_COLOR_DEPTH, d);
        write_reg(REG_TRANSFORM_FLAGS, f);
        settings++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Bytes that only fill the accumulator leave no trace in the backlog,
    // so the task waits on past an empty backlog before the block counts as idle.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (backlog != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_size(input bit is_width);
        int r;
        r = $urandom_range(0, 99);
        if (r < 58) return 16'($urandom_range(1, is_width ? 24 : 4));
        if (r < 66) return 16'd0;
        if (r < 78) return is_width ? 16'($urandom_range(25, 64)) : 16'($urandom_range(5, 12));
        if (r < 86) return 16'($urandom_range(256, 300));
        if (r < 95) return 16'($urandom_range(301, 65535));
        return 16'hFFFF;
    endfunction

    task automatic random_setting(input bit squeeze);
        logic [15:0] w, h;
        int eff_w, eff_h, full, n, i;
        w = pick_size(1'b1);
        h = pick_size(1'b0);
        if (squeeze) begin
            w = 16'd8;
            h = 16'd40;
        end
        configure(w, h, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        eff_w = (w == 16'd0) ? 1 : int'(w);
        eff_h = (h == 16'd0) ? 1 : int'(h);
        full = ((eff_w + 7) / 8) * eff_h;
        // Mostly whole images; the rest send one to ten bytes, which may stop mid-image
        // and be finished under whatever bounds the next setting brings.
        if (squeeze || (full <= 48 && $urandom_range(0, 99) < 85)) n = full;
        else n = $urandom_range(1, 10);
        tx_burst = squeeze || ($urandom_range(0, 3) == 0);
        squeeze_req = squeeze;
        for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
        squeeze_req = 1'b0;
        drain();
    endtask

    initial begin : stimulus
        int start_random;
        bit squeezed;
        squeezed = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Reset settings: width and height 1.
        send_byte(8'hFF);
        drain();
        // Zero sizes with both transforms.
        configure(16'd0, 16'd0, 16'd0, 16'd3);
        send_byte(8'h00);
        drain();
        // Largest sizes force the long header; the image is cut short below.
        configure(16'hFFFF, 16'hFFFF, 16'd255, 16'd1);
        send_byte(8'h01);
        send_byte(8'hFE);
        send_byte(8'h80);
        drain();
        // Bounds shrink mid-image, so the next byte closes it.
        configure(16'd8, 16'd1, 16'd0, 16'd0);
        send_byte(8'hA5);
        drain();
        configure(16'd255, 16'd255, 16'h0080, 16'd2);
        send_byte(8'h7F);
        send_byte(8'h00);
        drain();
        configure(16'd12, 16'd3, 16'd3, 16'd0);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h0F);
        send_byte(8'hF0);
        drain();
        configure(16'd7, 16'd2, 16'd1, 16'd3);
        send_byte(8'hFF);
        send_byte(8'h00);
        drain();
        configure(16'd17, 16'd1, 16'd9, 16'd1);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'hC3);
        drain();

        start_random = bytes_sent;
        while (bytes_sent - start_random < RANDOM_ITEMS) begin
            if (!squeezed && bytes_sent - start_random >= RANDOM_ITEMS / 2) begin
                random_setting(1'b1);
                squeezed = 1'b1;
            end else begin
                random_setting(1'b0);
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        $display("Summary: %0d source bytes over %0d register settings, %0d output bytes checked.",
                 bytes_sent, settings, checked);
        $display("Covered short and long headers, all transforms, zero and maximum sizes, "
                 , "mid-image bound changes and a long output stall.");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : receiver
        int gap;
        bit rx_burst;
        bit hold_done;
        rx_burst  = 1'b0;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 18);
            // One long hold while the sender keeps offering, to back up the input.
            if (squeeze_req && !hold_done) begin
                gap = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
